FILE: hw/rtl/bcds_pkg.sv
package bcds_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned TermW    = 2 * CodeW;
  localparam int unsigned SumW     = 31;
  localparam int unsigned MaxLanes = 4;
  localparam int unsigned NumQueriesDefault = 4;

  typedef enum logic [1:0] {
    MetricSqDiff  = 2'd0,
    MetricAbsDiff = 2'd1,
    MetricDot     = 2'd2
  } bcds_metric_e;

  // per-step control shared by all lanes
  typedef struct packed {
    logic         en;
    logic         last;
    bcds_metric_e metric;
  } bcds_ctrl_t;

endpackage

FILE: hw/rtl/byte_code_distance_sum.sv
// An accepted item waits in the input register and is added into the lane
// accumulators when it moves on; a last item's sums go to the output register.
// Throughput: one item per cycle, but a last item waits while an untaken result
// holds the output register; each lane's multiply-accumulate is combinational.
// Reset (rst_ni low, asynchronous): accumulators cleared, metric back to
// squared difference, no item held on either side.
module byte_code_distance_sum
  import bcds_pkg::*;
#(
  parameter int unsigned NUM_QUERIES = NumQueriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 metric_we_i,
  input  logic [1:0]           metric_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CodeW-1:0]     row_code_i,
  input  logic [CodeW-1:0]     query_code_0_i,
  input  logic [CodeW-1:0]     query_code_1_i,
  input  logic [CodeW-1:0]     query_code_2_i,
  input  logic [CodeW-1:0]     query_code_3_i,
  input  logic                 last_element_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SumW-1:0]      sum_0_o,
  output logic [SumW-1:0]      sum_1_o,
  output logic [SumW-1:0]      sum_2_o,
  output logic [SumW-1:0]      sum_3_o
);

  bcds_metric_e     metric_q;
  logic             s1_valid_q, s1_valid_d;
  logic             s1_last_q;
  logic [CodeW-1:0] s1_row_q;
  logic [CodeW-1:0] s1_query_q [MaxLanes];
  logic             out_valid_q, out_valid_d;
  logic [SumW-1:0]  out_sum_q [MaxLanes];
  logic [SumW-1:0]  lane_sum [MaxLanes];
  logic             in_fire, s1_adv, out_load;
  bcds_ctrl_t       ctrl;

  // a non-last item never blocks; a last one needs a free output slot
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = s1_adv && s1_last_q;

  assign ctrl.en     = s1_adv;
  assign ctrl.last   = s1_last_q;
  assign ctrl.metric = metric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetricSqDiff;
    end else if (metric_we_i) begin
      metric_q <= bcds_metric_e'(metric_i);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q     <= last_element_i;
      s1_row_q      <= row_code_i;
      s1_query_q[0] <= query_code_0_i;
      s1_query_q[1] <= query_code_1_i;
      s1_query_q[2] <= query_code_2_i;
      s1_query_q[3] <= query_code_3_i;
    end
  end

  for (genvar k = 0; k < MaxLanes; k++) begin : g_lane
    if (k < NUM_QUERIES) begin : g_used
      bcds_lane u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .row_i   (s1_row_q),
        .query_i (s1_query_q[k]),
        .sum_o   (lane_sum[k])
      );
    end else begin : g_unused
      assign lane_sum[k] = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q <= lane_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_0_o     = out_sum_q[0];
  assign sum_1_o     = out_sum_q[1];
  assign sum_2_o     = out_sum_q[2];
  assign sum_3_o     = out_sum_q[3];

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked last item");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result appeared without a last item");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !(s1_valid_q && s1_last_q)) |=> !out_valid_q)
    else $error("taken result not retired");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last_q) |-> s1_adv)
    else $error("non-last item held back");
`endif

endmodule

FILE: hw/rtl/bcds_lane.sv
module bcds_lane
  import bcds_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bcds_ctrl_t             ctrl_i,
  input  logic [CodeW-1:0]       row_i,
  input  logic [CodeW-1:0]       query_i,
  output logic [SumW-1:0]        sum_o
);

  logic [SumW-1:0]  acc_q, acc_d;
  logic [CodeW-1:0] diff;
  logic [CodeW-1:0] mul_a, mul_b;
  logic [TermW-1:0] prod, term;
  logic [SumW:0]    raw_sum;
  logic [SumW-1:0]  sat_sum;

  assign diff = (row_i >= query_i) ? (row_i - query_i) : (query_i - row_i);

  // one shared 8x8 multiplier: square of the difference or plain product
  always_comb begin
    case (ctrl_i.metric)
      MetricSqDiff: begin
        mul_a = diff;
        mul_b = diff;
      end
      default: begin
        mul_a = row_i;
        mul_b = query_i;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (ctrl_i.metric)
      MetricAbsDiff: term = {{(TermW-CodeW){1'b0}}, diff};
      default:       term = prod;
    endcase
  end

  assign raw_sum = {1'b0, acc_q} + {{(SumW+1-TermW){1'b0}}, term};
  assign sat_sum = raw_sum[SumW] ? {SumW{1'b1}} : raw_sum[SumW-1:0];
  assign sum_o   = sat_sum;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = ctrl_i.last ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import bcds_pkg::*;

  localparam logic [1:0]     MetricRsvd = 2'd3;  // undefined code, behaves as dot product
  localparam logic [SumW-1:0] SumCeil   = {SumW{1'b1}};
  localparam int unsigned    StallLimit = 1000;
  localparam int unsigned    MaxGap     = 18;
  localparam int unsigned    LongRowLen = 240;

  typedef logic [MaxLanes-1:0][SumW-1:0]  lane_sums_t;
  typedef logic [MaxLanes-1:0][CodeW-1:0] lane_codes_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             metric_we_i;
  logic [1:0]       metric_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CodeW-1:0] row_code_i;
  logic [CodeW-1:0] query_code_0_i;
  logic [CodeW-1:0] query_code_1_i;
  logic [CodeW-1:0] query_code_2_i;
  logic [CodeW-1:0] query_code_3_i;
  logic             last_element_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [SumW-1:0]  sum_0_o;
  logic [SumW-1:0]  sum_1_o;
  logic [SumW-1:0]  sum_2_o;
  logic [SumW-1:0]  sum_3_o;

  byte_code_distance_sum dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .metric_we_i    (metric_we_i),
    .metric_i       (metric_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .row_code_i     (row_code_i),
    .query_code_0_i (query_code_0_i),
    .query_code_1_i (query_code_1_i),
    .query_code_2_i (query_code_2_i),
    .query_code_3_i (query_code_3_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sum_0_o        (sum_0_o),
    .sum_1_o        (sum_1_o),
    .sum_2_o        (sum_2_o),
    .sum_3_o        (sum_3_o)
  );

  always #4 clk_i = ~clk_i;

  bit          src_idle;
  bit          sink_idle;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [1:0]  metric_now = MetricSqDiff;
  lane_sums_t  running_sum = '0;
  lane_sums_t  expected_sums[$];

  function automatic logic [TermW-1:0] code_term(logic [1:0] m, logic [CodeW-1:0] r,
                                                 logic [CodeW-1:0] q);
    logic [TermW-1:0] d;
    d = (r >= q) ? TermW'(r - q) : TermW'(q - r);
    case (m)
      MetricSqDiff:  return d * d;
      MetricAbsDiff: return d;
      default:       return TermW'(r) * TermW'(q);
    endcase
  endfunction

  function automatic logic [SumW-1:0] sat_accum(logic [SumW-1:0] acc, logic [TermW-1:0] t);
    logic [SumW:0] s;
    s = acc + t;
    return (s > SumCeil) ? SumCeil : s[SumW-1:0];
  endfunction

  // extremes show up often enough to hit zero distance and full-scale terms
  function automatic logic [CodeW-1:0] rand_code();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CodeW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_item(logic [CodeW-1:0] row, lane_codes_t qry, logic last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    row_code_i     <= row;
    query_code_0_i <= qry[0];
    query_code_1_i <= qry[1];
    query_code_2_i <= qry[2];
    query_code_3_i <= qry[3];
    last_element_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_sums.size() != 0);
  endtask

  task automatic set_metric(logic [1:0] m);
    wait_drained();
    repeat (4) @(posedge clk_i);
    metric_we_i <= 1'b1;
    metric_i    <= m;
    @(posedge clk_i);
    metric_now = m;
    metric_we_i <= 1'b0;
  endtask

  // reset metric first, then every code including the undefined one
  task automatic test_directed();
    logic [1:0] order [4];
    order = '{MetricSqDiff, MetricAbsDiff, MetricDot, MetricRsvd};
    for (int i = 0; i < 4; i++) begin
      if (i > 0) set_metric(order[i]);
      send_item(8'd255, {8'd1, 8'd128, 8'd255, 8'd0}, 1'b0);
      send_item(8'd0, {8'd254, 8'd127, 8'd0, 8'd255}, 1'b0);
      send_item(8'd128, {8'd129, 8'd128, 8'd255, 8'd0}, 1'b1);
      // single-element row
      send_item(i[0] ? 8'd0 : 8'd255, {4{8'd255}}, 1'b1);
    end
  endtask

  // one long row of near full-scale products, sent back to back
  task automatic test_long_row();
    set_metric(MetricDot);
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    for (int n = 0; n < LongRowLen; n++)
      send_item(8'd255, {8'd128, 8'd0, 8'd254, 8'd255}, n == LongRowLen - 1);
  endtask

  task automatic test_random_rows();
    logic [1:0]  plan [8];
    int unsigned rows;
    int unsigned sent;
    int unsigned len;
    lane_codes_t qry;
    plan = '{MetricDot, MetricSqDiff, MetricAbsDiff, MetricRsvd,
             MetricSqDiff, MetricDot, MetricAbsDiff, MetricRsvd};
    rows = 0;
    for (int p = 0; p < 8; p++) begin
      set_metric(plan[p]);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 170) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        for (int n = 0; n < len; n++) begin
          for (int k = 0; k < MaxLanes; k++) qry[k] = rand_code();
          send_item(rand_code(), qry, n == len - 1);
        end
        sent += len;
        rows++;
        // hold the sender until the output side has caught up
        if (rows == 3 || $urandom_range(0, 24) == 0) wait_drained();
      end
    end
  endtask

  always @(posedge clk_i) begin : predict_sums
    lane_codes_t qry;
    if (rst_ni && in_valid_i && in_ready_o) begin
      qry = {query_code_3_i, query_code_2_i, query_code_1_i, query_code_0_i};
      for (int k = 0; k < MaxLanes; k++)
        running_sum[k] = sat_accum(running_sum[k], code_term(metric_now, row_code_i, qry[k]));
      if (last_element_i) begin
        expected_sums.push_back(running_sum);
        running_sum = '0;
      end
    end
  end

  always @(posedge clk_i) begin : check_sums
    lane_sums_t got;
    lane_sums_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {sum_3_o, sum_2_o, sum_1_o, sum_0_o};
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected item, sum_0 %0d", got[0]));
      end else begin
        want = expected_sums.pop_front();
        for (int k = 0; k < MaxLanes; k++)
          if (got[k] !== want[k])
            report_mismatch($sformatf("sum_%0d expected %0d got %0d", k, want[k], got[k]));
      end
    end
  end

  initial begin : drain_results
    int unsigned stall;
    forever begin
      stall = sink_idle ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    metric_we_i    <= 1'b0;
    metric_i       <= MetricSqDiff;
    in_valid_i     <= 1'b0;
    row_code_i     <= '0;
    query_code_0_i <= '0;
    query_code_1_i <= '0;
    query_code_2_i <= '0;
    query_code_3_i <= '0;
    last_element_i <= 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_row();
    test_random_rows();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: byte_code_distance_sum.f
hw/rtl/bcds_pkg.sv
hw/rtl/bcds_lane.sv
hw/rtl/byte_code_distance_sum.sv
tb/testbench.sv
